FILE: rtl/apfd_pkg.sv
// Package for the allpass fractional feedback delay: sample and coefficient types,
// register indices, fixed-point constants and the saturation helper.
// No dependencies.
package apfd_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int RING_DEPTH_DEF  = 131072;
    localparam int COEF_FRAC       = 15;
    localparam int DELAY_BITS      = 17;
    localparam int GAIN_BITS       = 15;
    localparam int COEFF_BITS      = 16;
    localparam int CFG_DATA_BITS   = 17;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int TDATA_BITS      = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int ACC_BITS        = 34;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 17'd65536;
    localparam logic [GAIN_BITS-1:0]  FB_LIMIT    = 15'd32764;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DELAY_INT     = 2'd0,
        REG_ALLPASS_COEFF = 2'd1,
        REG_FEEDBACK_GAIN = 2'd2
    } reg_index_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEFF_BITS-1:0]  coeff_t;
    typedef logic [GAIN_BITS-1:0]          gain_t;
    typedef logic [DELAY_BITS-1:0]         delay_t;

    typedef struct packed {
        logic fwd;
        logic valid;
    } tap_ctl_t;

    function automatic sample_t sat_sample(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        hi = ACC_BITS'(signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
        lo = -hi - ACC_BITS'(1);
        if (v > hi) begin
            return SAMPLE_BITS'(hi);
        end else if (v < lo) begin
            return SAMPLE_BITS'(lo);
        end
        return SAMPLE_BITS'(v);
    endfunction

endpackage

FILE: rtl/apfd_ring.sv
// Ring memory holding both channels side by side, one write and one read port.
// Read data is registered. Uses apfd_pkg.
module apfd_ring #(
    parameter int RING_DEPTH = apfd_pkg::RING_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0]     wr_addr,
    input  logic [2*apfd_pkg::SAMPLE_BITS-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(RING_DEPTH)-1:0]     rd_addr,
    output logic [2*apfd_pkg::SAMPLE_BITS-1:0] rd_data
);
    import apfd_pkg::*;

    logic [2*SAMPLE_BITS-1:0] mem [RING_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/apfd_lane.sv
// One channel of the delay: feedback sum for the ring write, then the allpass
// interpolation on the tap. Holds the previous output and previous tap. Uses apfd_pkg.
module apfd_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                a_en,
    input  logic                b_en,
    input  apfd_pkg::sample_t   x_in,
    input  apfd_pkg::gain_t     gain,
    input  apfd_pkg::coeff_t    coeff,
    input  apfd_pkg::tap_ctl_t  ctl,
    input  apfd_pkg::sample_t   rd_data,
    output apfd_pkg::sample_t   w_out,
    output apfd_pkg::sample_t   y_out
);
    import apfd_pkg::*;

    sample_t y1_reg, y1_next;
    sample_t x1_reg, x1_next;
    sample_t w_reg,  w_next;

    logic signed [31:0]           fb_prod;
    logic signed [31:0]           fb_sh;
    logic signed [SAMPLE_BITS:0]  diff;
    logic signed [32:0]           ap_prod;
    logic signed [ACC_BITS-1:0]   ap_acc;

    always_comb begin
        fb_prod = signed'({1'b0, gain}) * y1_reg;
        fb_sh   = (fb_prod + 32'sd16384) >>> COEF_FRAC;
        w_next  = sat_sample(ACC_BITS'(fb_sh) + ACC_BITS'(x_in));
    end

    always_comb begin
        if (ctl.fwd) begin
            x1_next = w_reg;
        end else if (ctl.valid) begin
            x1_next = rd_data;
        end else begin
            x1_next = '0;
        end
        diff    = (SAMPLE_BITS+1)'(x1_next) - (SAMPLE_BITS+1)'(y1_reg);
        ap_prod = 33'(coeff) * 33'(diff);
        ap_acc  = ACC_BITS'(ap_prod) + (ACC_BITS'(x1_reg) <<< COEF_FRAC)
                + ACC_BITS'(34'sd16384);
        y1_next = sat_sample(ap_acc >>> COEF_FRAC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y1_reg <= '0;
            x1_reg <= '0;
        end else if (b_en) begin
            y1_reg <= y1_next;
            x1_reg <= x1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            w_reg <= w_next;
        end
    end

    assign w_out = w_next;
    assign y_out = y1_next;

endmodule

FILE: rtl/allpass_fractional_feedback_delay.sv
// Top level of the two-channel allpass fractional feedback delay.
// Depends on apfd_pkg, apfd_ring and apfd_lane.
//
// Usage: each input beat on s_* carries one frame, a sample per channel, and
// yields exactly one output beat on m_* with the delayed, interpolated samples.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata while the
// block is idle: index 0 is the integer delay, 1 the allpass coefficient and
// 2 the feedback gain, which is clamped to 32764.
// Frames are not taken back to back: the feedback term of a frame needs
// the output of the frame before it, and the tap arrives in the cycle after the
// ring read is issued. Each result is registered into the output queue before
// it is offered on m_*.
// A two-entry output queue decouples the sides, so a new frame is taken while
// a result still waits; when the receiver stalls and the queue is full,
// s_tready drops until a beat leaves.
// Reset clears the pointers, the filter history and the queue, and restores
// the register defaults. The ring is not swept: a fill mark makes every entry
// not yet written since reset read as zero, so no clearing pass is needed.
// RING_DEPTH must be a power of two.
module allpass_fractional_feedback_delay #(
    parameter int RING_DEPTH = apfd_pkg::RING_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_ch0 [15:0], sample_ch1 [31:16]
    input  logic [apfd_pkg::TDATA_BITS-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_ch0 [15:0], out_ch1 [31:16]
    output logic [apfd_pkg::TDATA_BITS-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [apfd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [apfd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import apfd_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);

    delay_t  delay_reg;
    coeff_t  coeff_reg;
    gain_t   gain_reg;

    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              full_reg;
    logic              b_busy_reg;
    tap_ctl_t          tap_ctl_reg, tap_ctl_next;

    logic [1:0]            cnt_reg;
    logic [TDATA_BITS-1:0] head_reg, tail_reg;

    logic                   a_fire;
    logic                   pop;
    sample_t                w0, w1, y0, y1;
    logic [2*SAMPLE_BITS-1:0] ring_rd;
    logic [TDATA_BITS-1:0]  res_word;

    assign s_tready = !b_busy_reg && (cnt_reg != 2'd2);
    assign a_fire   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head_reg;

    assign rd_addr = wp_reg - ADDR_W'(delay_reg);

    always_comb begin
        tap_ctl_next.fwd   = (rd_addr == wp_reg);
        tap_ctl_next.valid = full_reg || (rd_addr <= wp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
            coeff_reg <= '0;
            gain_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DELAY_INT:     delay_reg <= cfg_wdata[DELAY_BITS-1:0];
                REG_ALLPASS_COEFF: coeff_reg <= cfg_wdata[COEFF_BITS-1:0];
                REG_FEEDBACK_GAIN: begin
                    gain_reg <= (cfg_wdata[GAIN_BITS-1:0] > FB_LIMIT) ?
                                FB_LIMIT : cfg_wdata[GAIN_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            full_reg    <= 1'b0;
            b_busy_reg  <= 1'b0;
            tap_ctl_reg <= '0;
        end else begin
            b_busy_reg <= a_fire;
            if (a_fire) begin
                wp_reg      <= wp_reg + ADDR_W'(1);
                tap_ctl_reg <= tap_ctl_next;
                if (wp_reg == {ADDR_W{1'b1}}) begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    apfd_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (a_fire),
        .wr_addr (wp_reg),
        .wr_data ({w1, w0}),
        .rd_en   (a_fire),
        .rd_addr (rd_addr),
        .rd_data (ring_rd)
    );

    apfd_lane u_lane0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_en    (a_fire),
        .b_en    (b_busy_reg),
        .x_in    (s_tdata[SAMPLE_BITS-1:0]),
        .gain    (gain_reg),
        .coeff   (coeff_reg),
        .ctl     (tap_ctl_reg),
        .rd_data (ring_rd[SAMPLE_BITS-1:0]),
        .w_out   (w0),
        .y_out   (y0)
    );

    apfd_lane u_lane1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_en    (a_fire),
        .b_en    (b_busy_reg),
        .x_in    (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .gain    (gain_reg),
        .coeff   (coeff_reg),
        .ctl     (tap_ctl_reg),
        .rd_data (ring_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .w_out   (w1),
        .y_out   (y1)
    );

    assign res_word = TDATA_BITS'({y1, y0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            priority if (b_busy_reg && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (!b_busy_reg && pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end else begin
                cnt_reg <= cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (b_busy_reg && pop) begin
            if (cnt_reg == 2'd1) begin
                head_reg <= res_word;
            end else begin
                head_reg <= tail_reg;
                tail_reg <= res_word;
            end
        end else if (b_busy_reg) begin
            if (cnt_reg == 2'd0) begin
                head_reg <= res_word;
            end else begin
                tail_reg <= res_word;
            end
        end else if (pop) begin
            head_reg <= tail_reg;
        end else begin
            head_reg <= head_reg;
        end
    end

endmodule

FILE: rtl/apfd_checker.sv
// Port-level checker for the allpass fractional feedback delay and its bind.
// Depends on apfd_pkg for the data width.
module apfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [apfd_pkg::TDATA_BITS-1:0] m_tdata
);
    import apfd_pkg::*;

    // A stalled output beat keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Frames are never taken back to back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat accepted in consecutive cycles");

    // Every accepted frame is followed by the output offering a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result not offered after an accepted frame");

    // Reset empties the output and opens the input.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the output queue");

endmodule

bind allpass_fractional_feedback_delay apfd_checker u_apfd_checker (.*);
